// ----- rtl/urp_pkg.sv -----
// ----------------------------------------------------------------------------
// urp_pkg: shared constants and helpers for the unique random permutation block
// Holds the generator constants and the shift register step function.
// ----------------------------------------------------------------------------
package urp_pkg;

   localparam int unsigned ValueWidth = 31;
   localparam int unsigned CountWidth = 13;
   localparam int unsigned PosWidth   = 12;

   localparam logic [30:0] LcgMod  = 31'h7FFF_FFFF;
   localparam logic [14:0] LcgMult = 15'd16807;

   localparam logic [0:0] CsrSeed  = 1'b0;
   localparam logic [0:0] CsrCount = 1'b1;

   function automatic logic [30:0] shift_next(input logic [30:0] s);
      logic fb;
      fb = s[0] ^ s[3];
      return {fb, s[30:1]};
   endfunction

endpackage

// ----- rtl/urp_ram.sv -----
// ----------------------------------------------------------------------------
// urp_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module urp_ram #(
   parameter int unsigned WIDTH = 31,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/urp_lcg.sv -----
// ----------------------------------------------------------------------------
// urp_lcg: Park-Miller generator step and reduction modulo the run length
// Steps x*16807 mod 2^31-1 (multiply, fold), then a restoring remainder by n.
// ----------------------------------------------------------------------------
module urp_lcg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [30:0]                     x_in,
   input  logic [urp_pkg::CountWidth-1:0]  n_in,
   output logic                            done,
   output logic [30:0]                     x_out,
   output logic [31:0]                     j_out
);

   localparam int unsigned CW = urp_pkg::CountWidth - 1;

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_FOLD, S_REM} state_type;

   state_type   state_ff;
   logic [45:0] prod_ff;
   logic [30:0] x_ff;
   logic [31:0] rem_ff;
   logic [4:0]  bit_ff;
   logic [CW:0] n_ff;
   logic        done_ff;

   logic [31:0] fold_in;
   logic [30:0] fold_mod;
   logic [31:0] trial;
   logic [31:0] rem_shift;

   always_comb begin
      fold_in  = {1'b0, prod_ff[30:0]} + {17'd0, prod_ff[45:31]};
      fold_mod = (fold_in >= {1'b0, urp_pkg::LcgMod}) ?
                 31'(fold_in - {1'b0, urp_pkg::LcgMod}) : fold_in[30:0];
      rem_shift = {rem_ff[30:0], x_ff[bit_ff]};
      trial     = rem_shift - {19'd0, n_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  prod_ff  <= 46'(x_in) * 46'(urp_pkg::LcgMult);
                  n_ff     <= n_in;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               state_ff <= S_FOLD;
            end
            S_FOLD: begin
               // Zero maps back to the modulus so an all-ones state stays put.
               x_ff     <= (fold_mod == 31'd0) ? urp_pkg::LcgMod : fold_mod;
               rem_ff   <= 32'd0;
               bit_ff   <= 5'd30;
               state_ff <= S_REM;
            end
            S_REM: begin
               rem_ff <= trial[31] ? rem_shift : trial;
               if (bit_ff == 5'd0) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
               bit_ff <= bit_ff - 5'd1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign j_out = rem_ff;

endmodule

// ----- rtl/unique_random_permutation.sv -----
// ----------------------------------------------------------------------------
// unique_random_permutation: shuffled run of distinct 31-bit values
// Fills a table from a shift register, shuffles it with a Park-Miller
// generator, and hands out one entry per request word with request set.
// ----------------------------------------------------------------------------
// Usage: the requester raises req_valid with req_request set. A word with
// request low is accepted and dropped. Each accepted request yields one
// rsp word with value, position in the run and a last flag on the final
// entry. The request after last starts a new run.
// Csr index 0 writes the seed, index 1 the run length (count); both take
// effect at the next run.
// Run start: a request that starts a run waits for the fill of the table
// and the shuffle (per position: a start, the multiply and fold, a 31-step
// bit-serial remainder, a handoff, then two reads and two writes of the
// table memory). Later requests of the run get the table read in S_RD and
// their rsp word registered in S_RD_WAIT. One request is in work at a time.
// The result waits in the rsp register while rsp_stall is high; the block
// takes no new request until it is delivered.
// Reset restores the state machine, CSR and run registers to defaults; the
// table is not cleared and needs no clearing pass since every run fills the entries it reads.
// ----------------------------------------------------------------------------
module unique_random_permutation #(
   parameter int unsigned DEPTH = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_request,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [urp_pkg::ValueWidth-1:0]   rsp_value,
   output logic [urp_pkg::PosWidth-1:0]     rsp_position,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [0:0]                       csr_index,
   input  logic [30:0]                      csr_wr_data
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned LW = AW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_SEED, S_SEED_WAIT, S_FILL, S_SH_STEP, S_SH_WAIT,
      S_SH_RDI, S_SH_RDJ, S_SH_WRI, S_SH_WRJ, S_RD, S_RD_WAIT, S_OUT
   } state_type;

   state_type    state_ff;
   logic [30:0]  seed_ff;
   logic [12:0]  count_ff;
   logic         pend_ff;
   logic [30:0]  shift_ff;
   logic [30:0]  lcg_ff;
   logic [LW-1:0] len_ff;
   logic [LW-1:0] idx_ff;
   logic [AW-1:0] j_ff;
   logic [30:0]  vi_ff;
   logic [LW-1:0] rpos_ff;
   logic         ready_ff;
   logic         rsp_valid_ff;
   logic [30:0]  rsp_value_ff;
   logic [11:0]  rsp_pos_ff;
   logic         rsp_last_ff;

   logic         ram_we;
   logic [AW-1:0] ram_addr;
   logic [30:0]  ram_wdata;
   logic [30:0]  ram_rdata;

   logic         lcg_start;
   logic [30:0]  lcg_x_in;
   logic         lcg_done;
   logic [30:0]  lcg_x_out;
   logic [31:0]  lcg_j;
   logic [LW-1:0] len_in;
   logic [30:0]  shift_in;

   urp_ram #(.WIDTH(31), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   urp_lcg u_lcg (
      .clock (clock),
      .reset (reset),
      .start (lcg_start),
      .x_in  (lcg_x_in),
      .n_in  (13'(len_ff)),
      .done  (lcg_done),
      .x_out (lcg_x_out),
      .j_out (lcg_j)
   );

   // Saturate the run length to the table depth; zero counts as one.
   always_comb begin
      if (count_ff == 13'd0) begin
         len_in = LW'(1);
      end else if (32'(count_ff) > DEPTH) begin
         len_in = LW'(DEPTH);
      end else begin
         len_in = LW'(count_ff);
      end
      shift_in = urp_pkg::shift_next(shift_ff);
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = idx_ff[AW-1:0];
      ram_wdata = shift_in;
      lcg_start = 1'b0;
      lcg_x_in  = lcg_ff;
      case (state_ff)
         S_SEED: begin
            lcg_start = 1'b1;
            if (seed_ff != 31'd0) begin
               lcg_x_in = seed_ff;
            end
         end
         S_FILL:    ram_we = 1'b1;
         S_SH_STEP: lcg_start = 1'b1;
         S_SH_RDJ:  ram_addr = j_ff;
         S_SH_WRI: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
         end
         S_SH_WRJ: begin
            ram_we    = 1'b1;
            ram_addr  = j_ff;
            ram_wdata = vi_ff;
         end
         S_RD: ram_addr = rpos_ff[AW-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= 31'd1;
         count_ff     <= 13'd1024;
         pend_ff      <= 1'b1;
         shift_ff     <= 31'd1;
         lcg_ff       <= 31'd16807;
         ready_ff     <= 1'b0;
         rpos_ff      <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               urp_pkg::CsrSeed: begin
                  seed_ff <= csr_wr_data;
                  pend_ff <= 1'b1;
               end
               urp_pkg::CsrCount: count_ff <= csr_wr_data[12:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_request) begin
                  if (ready_ff) begin
                     state_ff <= S_RD;
                  end else begin
                     len_ff   <= len_in;
                     idx_ff   <= '0;
                     state_ff <= pend_ff ? S_SEED : S_FILL;
                  end
               end
            end
            S_SEED: begin
               pend_ff  <= 1'b0;
               state_ff <= S_SEED_WAIT;
            end
            S_SEED_WAIT: begin
               if (lcg_done) begin
                  lcg_ff   <= lcg_x_out;
                  state_ff <= S_FILL;
               end
            end
            S_FILL: begin
               shift_ff <= shift_in;
               if (idx_ff == len_ff - LW'(1)) begin
                  idx_ff   <= '0;
                  state_ff <= S_SH_STEP;
               end else begin
                  idx_ff <= idx_ff + LW'(1);
               end
            end
            S_SH_STEP: state_ff <= S_SH_WAIT;
            S_SH_WAIT: begin
               if (lcg_done) begin
                  lcg_ff   <= lcg_x_out;
                  j_ff     <= AW'(lcg_j);
                  state_ff <= S_SH_RDI;
               end
            end
            S_SH_RDI: state_ff <= S_SH_RDJ;
            S_SH_RDJ: begin
               vi_ff    <= ram_rdata;
               state_ff <= S_SH_WRI;
            end
            S_SH_WRI: state_ff <= S_SH_WRJ;
            S_SH_WRJ: begin
               if (idx_ff == len_ff - LW'(1)) begin
                  rpos_ff  <= '0;
                  ready_ff <= 1'b1;
                  state_ff <= S_RD;
               end else begin
                  idx_ff   <= idx_ff + LW'(1);
                  state_ff <= S_SH_STEP;
               end
            end
            S_RD: state_ff <= S_RD_WAIT;
            S_RD_WAIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_value_ff <= ram_rdata;
               rsp_pos_ff   <= 12'(rpos_ff);
               rsp_last_ff  <= (rpos_ff + LW'(1) == len_ff);
               if (rpos_ff + LW'(1) == len_ff) begin
                  rpos_ff  <= '0;
                  ready_ff <= 1'b0;
               end else begin
                  rpos_ff <= rpos_ff + LW'(1);
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_last     = rsp_last_ff;

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while idle");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> !ready_ff)
      else $error("run still ready after last");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_value_ff))
      else $error("stalled result changed");

endmodule
